@@ hw/rtl/bpp_pkg.sv @@
// shared types and constants of the balance controller
package bpp_pkg;

  // register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_TILT_REF        = 3'd0,
    REG_UPRIGHT_P_GAIN  = 3'd1,
    REG_UPRIGHT_D_GAIN  = 3'd2,
    REG_SPEED_P_GAIN    = 3'd3,
    REG_SPEED_I_GAIN    = 3'd4,
    REG_TARGET_SPEED    = 3'd5,
    REG_TARGET_POSITION = 3'd6,
    REG_TILT_LIMIT      = 3'd7
  } reg_index_e;

  // operand pairs of the shared multiplier
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_P_ERR,
    MUL_D_GYRO,
    MUL_KEEP_FILT,
    MUL_NEW_SUM,
    MUL_SP_SPEED,
    MUL_SI_INTEG
  } mul_sel_e;

  // accumulator actions on the previous product
  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_CLEAR,
    ACC_ADD_P,
    ACC_ADD_D,
    ACC_ADD_S
  } acc_op_e;

  typedef struct packed {
    logic signed [14:0] tilt_ref;
    logic signed [15:0] upright_p_gain;
    logic signed [15:0] upright_d_gain;
    logic signed [15:0] speed_p_gain;
    logic signed [15:0] speed_i_gain;
    logic signed [15:0] target_speed;
    logic signed [14:0] target_position;
    logic        [13:0] tilt_limit;
  } cfg_t;

  // controller to datapath commands
  typedef struct packed {
    logic     load;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    logic     save_keep;
    logic     filt_upd;
    logic     integ_upd;
    logic     commit;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;
  } status_t;

  localparam logic [13:0] TILT_LIMIT_RESET = 14'd2880;
  localparam logic signed [17:0] COEF_KEEP = 18'sd45875;
  localparam logic signed [17:0] COEF_NEW = 18'sd19661;
  localparam logic signed [35:0] FILT_MAX = 36'sd2147483647;
  localparam logic signed [35:0] FILT_MIN = -36'sd2147483648;
  localparam logic signed [33:0] INTEG_MAX = 34'sd983040000;
  localparam logic signed [33:0] INTEG_MIN = -34'sd983040000;
  localparam logic [14:0] DRIVE_LIMIT = 15'd32767;
  localparam logic [15:0] RIGHT_PWM_BIAS = 16'd5;
  localparam logic [15:0] ZONE_NEAR = 16'd10;
  localparam logic [15:0] ZONE_FAR = 16'd30;
  localparam logic signed [4:0] OFFSET_MID = -5'sd5;
  localparam logic signed [4:0] OFFSET_NEAR = 5'sd8;

endpackage

@@ hw/rtl/bpp_cfg.sv @@
// configuration register file of the balance controller
module bpp_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_index_i,
  input  logic [15:0]   cfg_data_i,
  output bpp_pkg::cfg_t cfg_o
);
  import bpp_pkg::*;

  cfg_t cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{tilt_limit: TILT_LIMIT_RESET, default: '0};
    end else if (cfg_we_i) begin
      case (reg_index_e'(cfg_index_i))
        REG_TILT_REF:        cfg_q.tilt_ref <= cfg_data_i[14:0];
        REG_UPRIGHT_P_GAIN:  cfg_q.upright_p_gain <= cfg_data_i;
        REG_UPRIGHT_D_GAIN:  cfg_q.upright_d_gain <= cfg_data_i;
        REG_SPEED_P_GAIN:    cfg_q.speed_p_gain <= cfg_data_i;
        REG_SPEED_I_GAIN:    cfg_q.speed_i_gain <= cfg_data_i;
        REG_TARGET_SPEED:    cfg_q.target_speed <= cfg_data_i;
        REG_TARGET_POSITION: cfg_q.target_position <= cfg_data_i[14:0];
        REG_TILT_LIMIT:      cfg_q.tilt_limit <= cfg_data_i[13:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hw/rtl/bpp_ctrl.sv @@
// sequencing state machine of the balance controller
module bpp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  bpp_pkg::status_t status_i,
  output bpp_pkg::cmd_t    cmd_o
);
  import bpp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_PE, S_DG, S_FK, S_FN, S_FILT, S_INTEG, S_SP, S_SI, S_ACC, S_FIN
  } state_e;

  state_e state_q;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE:  if (in_valid_i) state_q <= S_PE;
        S_PE:    state_q <= S_DG;
        S_DG:    state_q <= S_FK;
        S_FK:    state_q <= S_FN;
        S_FN:    state_q <= S_FILT;
        S_FILT:  state_q <= S_INTEG;
        S_INTEG: state_q <= S_SP;
        S_SP:    state_q <= S_SI;
        S_SI:    state_q <= S_ACC;
        S_ACC:   state_q <= S_FIN;
        S_FIN:   if (status_i.out_free) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // command decode
  always_comb begin
    cmd_o = '0;
    cmd_o.mul_sel = MUL_NONE;
    cmd_o.acc_op = ACC_HOLD;
    case (state_q)
      S_IDLE:  cmd_o.load = in_valid_i;
      S_PE: begin
        cmd_o.mul_sel = MUL_P_ERR;
        cmd_o.acc_op = ACC_CLEAR;
      end
      S_DG: begin
        cmd_o.mul_sel = MUL_D_GYRO;
        cmd_o.acc_op = ACC_ADD_P;
      end
      S_FK: begin
        cmd_o.mul_sel = MUL_KEEP_FILT;
        cmd_o.acc_op = ACC_ADD_D;
      end
      S_FN: begin
        cmd_o.mul_sel = MUL_NEW_SUM;
        cmd_o.save_keep = 1'b1;
      end
      S_FILT:  cmd_o.filt_upd = 1'b1;
      S_INTEG: cmd_o.integ_upd = 1'b1;
      S_SP:    cmd_o.mul_sel = MUL_SP_SPEED;
      S_SI: begin
        cmd_o.mul_sel = MUL_SI_INTEG;
        cmd_o.acc_op = ACC_ADD_S;
      end
      S_ACC:   cmd_o.acc_op = ACC_ADD_S;
      S_FIN:   cmd_o.commit = status_i.out_free;
      default: ;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  // a request is taken only when no item is at work
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == S_PE)
    else $error("load did not start a tick");
  a_commit_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> state_q == S_FIN && !in_ready_o)
    else $error("commit outside final step");
  a_wait_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FIN && !status_i.out_free |=> state_q == S_FIN)
    else $error("result dropped while output busy");

endmodule

@@ hw/rtl/bpp_dp.sv @@
// datapath: shared multiplier, accumulator, loop state and output register
module bpp_dp #(
  parameter int TICKS_PER_RANGING = 20
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bpp_pkg::cfg_t      cfg_i,
  input  bpp_pkg::cmd_t      cmd_i,
  output bpp_pkg::status_t   status_o,
  input  logic signed [14:0] tilt_angle_i,
  input  logic signed [15:0] gyro_rate_i,
  input  logic signed [15:0] left_count_i,
  input  logic signed [15:0] right_count_i,
  input  logic        [15:0] range_distance_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] drive_value_o,
  output logic        [14:0] left_pwm_o,
  output logic        [15:0] right_pwm_o,
  output logic               forward_o,
  output logic               motors_enabled_o
);
  import bpp_pkg::*;

  localparam logic [4:0] TickLast = 5'(TICKS_PER_RANGING);

  // latched inputs
  logic signed [15:0] err_q;
  logic signed [15:0] gyro_q;
  logic signed [16:0] sum_q;
  logic        [15:0] dist_q;

  // loop state
  logic signed [31:0] filt_q, filt_d;
  logic signed [31:0] integ_q, integ_d;
  logic signed [4:0]  offset_q, offset_d;
  logic        [4:0]  tick_q, tick_d;
  logic               dir_q;

  // arithmetic registers
  logic signed [50:0] prod_q;
  logic signed [50:0] keep_q;
  logic signed [51:0] acc_q;

  // output register
  logic               out_valid_q;
  logic signed [15:0] drive_q;
  logic        [14:0] lpwm_q;
  logic        [15:0] rpwm_q;
  logic               en_q;

  // multiplier operand select
  logic signed [32:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [50:0] mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_sel)
      MUL_P_ERR: begin
        mul_a = 33'(err_q);
        mul_b = 18'(cfg_i.upright_p_gain);
      end
      MUL_D_GYRO: begin
        mul_a = 33'(gyro_q);
        mul_b = 18'(cfg_i.upright_d_gain);
      end
      MUL_KEEP_FILT: begin
        mul_a = 33'(filt_q);
        mul_b = COEF_KEEP;
      end
      MUL_NEW_SUM: begin
        mul_a = 33'(sum_q);
        mul_b = COEF_NEW;
      end
      MUL_SP_SPEED: begin
        mul_a = 33'(filt_q) - 33'(signed'({cfg_i.target_speed, 16'd0}));
        mul_b = 18'(cfg_i.speed_p_gain);
      end
      MUL_SI_INTEG: begin
        mul_a = 33'(integ_q) - 33'(signed'({cfg_i.target_position, 16'd0}));
        mul_b = 18'(cfg_i.speed_i_gain);
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // filter update, round half up then saturate
  logic signed [51:0] fsum;
  logic signed [35:0] fsh;

  always_comb begin
    fsum = 52'(keep_q) + 52'(signed'({prod_q[35:0], 16'd0})) + 52'sd32768;
    fsh = fsum[51:16];
    if (fsh > FILT_MAX) filt_d = 32'sh7fffffff;
    else if (fsh < FILT_MIN) filt_d = 32'sh80000000;
    else filt_d = fsh[31:0];
  end

  // integral update with ultrasonic offset, clamped
  logic signed [33:0] isum;

  always_comb begin
    isum = 34'(integ_q) + 34'(filt_q) + 34'(signed'({offset_q, 16'd0}));
    if (isum > INTEG_MAX) integ_d = INTEG_MAX[31:0];
    else if (isum < INTEG_MIN) integ_d = INTEG_MIN[31:0];
    else integ_d = isum[31:0];
  end

  // drive truncation, saturation and enable
  logic               acc_neg;
  logic        [51:0] acc_abs;
  logic        [27:0] mag_full;
  logic        [14:0] mag_sat;
  logic signed [15:0] drive_raw;
  logic        [15:0] err_abs;
  logic               enabled;
  logic        [14:0] mag_out;

  always_comb begin
    acc_neg = acc_q[51];
    acc_abs = acc_neg ? 52'(-acc_q) : 52'(acc_q);
    mag_full = acc_abs[51:24];
    mag_sat = (mag_full > 28'(DRIVE_LIMIT)) ? DRIVE_LIMIT : mag_full[14:0];
    drive_raw = acc_neg ? -signed'({1'b0, mag_sat}) : signed'({1'b0, mag_sat});
    err_abs = err_q[15] ? 16'(-err_q) : 16'(err_q);
    enabled = err_abs <= {2'b00, cfg_i.tilt_limit};
    mag_out = enabled ? mag_sat : '0;
  end

  // ranging schedule
  always_comb begin
    tick_d = tick_q + 5'd1;
    offset_d = offset_q;
    if (tick_d >= TickLast) begin
      tick_d = '0;
      if (dist_q >= ZONE_NEAR && dist_q < ZONE_FAR) offset_d = OFFSET_MID;
      else if (dist_q != '0 && dist_q < ZONE_NEAR) offset_d = OFFSET_NEAR;
      else offset_d = '0;
    end
  end

  // input latch, arithmetic and output registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      err_q <= 16'(tilt_angle_i) - 16'(cfg_i.tilt_ref);
      gyro_q <= gyro_rate_i;
      sum_q <= 17'(left_count_i) + 17'(right_count_i);
      dist_q <= range_distance_i;
    end
    prod_q <= mul_p;
    if (cmd_i.save_keep) keep_q <= prod_q;
    case (cmd_i.acc_op)
      ACC_CLEAR: acc_q <= '0;
      ACC_ADD_P: acc_q <= acc_q + signed'({prod_q[41:0], 10'd0});
      ACC_ADD_D: acc_q <= acc_q + signed'({prod_q[35:0], 16'd0});
      ACC_ADD_S: acc_q <= acc_q + 52'(prod_q);
      default: ;
    endcase
    if (cmd_i.commit) begin
      drive_q <= enabled ? drive_raw : '0;
      lpwm_q <= mag_out;
      rpwm_q <= {1'b0, mag_out} + RIGHT_PWM_BIAS;
      en_q <= enabled;
    end
  end

  // loop state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q <= '0;
      integ_q <= '0;
      offset_q <= '0;
      tick_q <= '0;
      dir_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.filt_upd) filt_q <= filt_d;
      if (cmd_i.integ_upd) integ_q <= integ_d;
      if (cmd_i.commit) begin
        tick_q <= tick_d;
        offset_q <= offset_d;
        if (enabled) dir_q <= (drive_raw > 16'sd0);
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign drive_value_o = drive_q;
  assign left_pwm_o = lpwm_q;
  assign right_pwm_o = rpwm_q;
  assign forward_o = dir_q;
  assign motors_enabled_o = en_q;

  a_disabled_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !motors_enabled_o |-> drive_value_o == 16'sd0 && left_pwm_o == '0)
    else $error("drive not zero while motors disabled");
  a_pwm_bias: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> right_pwm_o == {1'b0, left_pwm_o} + RIGHT_PWM_BIAS)
    else $error("right pwm bias broken");
  a_integ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    34'(integ_q) <= INTEG_MAX && 34'(integ_q) >= INTEG_MIN)
    else $error("speed integral out of clamp range");
  a_tick_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_q < TickLast)
    else $error("tick counter passed ranging period");
  a_dir_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && !enabled |=> $stable(dir_q))
    else $error("direction changed while disabled");

endmodule

@@ hw/rtl/balance_robot_pd_pi_step_top.sv @@
// top level of the cascaded upright pd and speed pi balance controller
//
// One request is one control tick. After it is taken the block steps through
// the states PE, DG, FK, FN, FILT, INTEG, SP, SI, ACC and FIN, and a new tick
// is taken in the cycle after the result is written to the output register;
// FIN holds while the output side stalls. The single 33x18 signed multiplier
// is used six times per tick (two upright terms, two filter products, two
// speed loop terms), besides the filter, integral and output steps.
// A finished result waits in the output register while the next
// tick is taken and computed; it is written once the register is free.
// Configuration writes take effect at once and no clearing pass is needed
// after reset.
module balance_robot_pd_pi_step_top #(
  parameter int TICKS_PER_RANGING = 20
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [14:0] tilt_angle_i,
  input  logic signed [15:0] gyro_rate_i,
  input  logic signed [15:0] left_count_i,
  input  logic signed [15:0] right_count_i,
  input  logic        [15:0] range_distance_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] drive_value_o,
  output logic        [14:0] left_pwm_o,
  output logic        [15:0] right_pwm_o,
  output logic               forward_o,
  output logic               motors_enabled_o
);
  import bpp_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  // configuration registers
  bpp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // sequencer
  bpp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath
  bpp_dp #(
    .TICKS_PER_RANGING (TICKS_PER_RANGING)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .cmd_i            (cmd),
    .status_o         (status),
    .tilt_angle_i     (tilt_angle_i),
    .gyro_rate_i      (gyro_rate_i),
    .left_count_i     (left_count_i),
    .right_count_i    (right_count_i),
    .range_distance_i (range_distance_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .drive_value_o    (drive_value_o),
    .left_pwm_o       (left_pwm_o),
    .right_pwm_o      (right_pwm_o),
    .forward_o        (forward_o),
    .motors_enabled_o (motors_enabled_o)
  );

endmodule

@@ dv/tb_balance_robot_pd_pi_step_top.sv @@
// testbench of the balance controller: directed and random control ticks checked by a predictor
module tb_balance_robot_pd_pi_step_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bpp_pkg::*;

  localparam int TICKS_PER_RANGING = 20;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_TICKS = 108;
  localparam int QUIET_LIMIT = 5000;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic signed [14:0] tilt;
    logic signed [15:0] gyro;
    logic signed [15:0] lcnt;
    logic signed [15:0] rcnt;
    logic        [15:0] range_cm;
  } tick_t;

  typedef struct packed {
    logic signed [15:0] drive;
    logic        [14:0] lpwm;
    logic        [15:0] rpwm;
    logic               fwd;
    logic               en;
  } drive_res_t;

  typedef struct packed {
    tick_t      t;
    logic       typed;
    drive_res_t want;
  } stim_row_t;

  // zero drive with forward low: what the block gives with all gains at reset
  localparam drive_res_t HELD_ON  = '{16'sd0, 15'd0, 16'd5, 1'b0, 1'b1};
  localparam drive_res_t HELD_OFF = '{16'sd0, 15'd0, 16'd5, 1'b0, 1'b0};

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_index_i = '0;
  logic [15:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [14:0] tilt_angle_i = '0;
  logic signed [15:0] gyro_rate_i = '0;
  logic signed [15:0] left_count_i = '0;
  logic signed [15:0] right_count_i = '0;
  logic        [15:0] range_distance_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [15:0] drive_value_o;
  logic        [14:0] left_pwm_o;
  logic        [15:0] right_pwm_o;
  logic               forward_o;
  logic               motors_enabled_o;

  balance_robot_pd_pi_step_top #(
    .TICKS_PER_RANGING(TICKS_PER_RANGING)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .tilt_angle_i    (tilt_angle_i),
    .gyro_rate_i     (gyro_rate_i),
    .left_count_i    (left_count_i),
    .right_count_i   (right_count_i),
    .range_distance_i(range_distance_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .drive_value_o   (drive_value_o),
    .left_pwm_o      (left_pwm_o),
    .right_pwm_o     (right_pwm_o),
    .forward_o       (forward_o),
    .motors_enabled_o(motors_enabled_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor copy of registers and controller state
  cfg_t       ctl_cfg;
  longint     speed_filt;
  longint     speed_integ;
  longint     range_offset;
  int         tick_cnt;
  logic       dir_hold;

  drive_res_t pending_drive_q[$];
  stim_row_t  stim_rows[$];

  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int mismatches = 0;
  int results_checked = 0;
  int ticks_sent = 0;
  int settings_loaded = 0;
  int quiet_cycles = 0;
  int n_disabled = 0;
  int n_drive_sat = 0;
  int n_filt_sat = 0;
  int n_integ_clamp = 0;
  int n_zone_near = 0;
  int n_zone_mid = 0;
  int n_zone_clear = 0;

  // one control tick of the cascaded loops, updates the predictor state
  function automatic drive_res_t control_step(tick_t t);
    longint     err;
    longint     acc;
    longint     enc_sum;
    longint     mag;
    longint     drv;
    logic       en;
    drive_res_t res;
    // upright pd, exact in q.24
    err = longint'($signed(t.tilt)) - longint'($signed(ctl_cfg.tilt_ref));
    acc = longint'($signed(ctl_cfg.upright_p_gain)) * err * 1024
        + longint'($signed(ctl_cfg.upright_d_gain)) * longint'($signed(t.gyro)) * 65536;
    // speed filter, round half up, saturate to 32 bits
    enc_sum = longint'($signed(t.lcnt)) + longint'($signed(t.rcnt));
    speed_filt = (longint'(COEF_KEEP) * speed_filt
                  + longint'(COEF_NEW) * (enc_sum * 65536) + 32768) >>> 16;
    if (speed_filt > longint'(FILT_MAX)) begin
      speed_filt = longint'(FILT_MAX);
      n_filt_sat++;
    end else if (speed_filt < longint'(FILT_MIN)) begin
      speed_filt = longint'(FILT_MIN);
      n_filt_sat++;
    end
    // integral with ultrasonic offset, clamped
    speed_integ = speed_integ + speed_filt + range_offset * 65536;
    if (speed_integ > longint'(INTEG_MAX)) begin
      speed_integ = longint'(INTEG_MAX);
      n_integ_clamp++;
    end else if (speed_integ < longint'(INTEG_MIN)) begin
      speed_integ = longint'(INTEG_MIN);
      n_integ_clamp++;
    end
    // speed pi terms
    acc += longint'($signed(ctl_cfg.speed_p_gain))
         * (speed_filt - longint'($signed(ctl_cfg.target_speed)) * 65536);
    acc += longint'($signed(ctl_cfg.speed_i_gain))
         * (speed_integ - longint'($signed(ctl_cfg.target_position)) * 65536);
    // truncate toward zero and saturate
    mag = (acc < 0 ? -acc : acc) >>> 24;
    if (mag > longint'(DRIVE_LIMIT)) begin
      mag = longint'(DRIVE_LIMIT);
      n_drive_sat++;
    end
    drv = acc < 0 ? -mag : mag;
    // tilt guard, direction held while disabled
    en = (err < 0 ? -err : err) <= longint'(ctl_cfg.tilt_limit);
    if (en) begin
      dir_hold = drv > 0;
    end else begin
      drv = 0;
      n_disabled++;
    end
    mag = drv < 0 ? -drv : drv;
    res.drive = 16'(drv);
    res.lpwm = 15'(mag);
    res.rpwm = 16'(mag) + RIGHT_PWM_BIAS;
    res.fwd = dir_hold;
    res.en = en;
    // ranging schedule, the new offset acts from the next tick
    tick_cnt = (tick_cnt + 1) % 32;
    if (tick_cnt >= TICKS_PER_RANGING) begin
      tick_cnt = 0;
      if (t.range_cm >= ZONE_NEAR && t.range_cm < ZONE_FAR) begin
        range_offset = longint'(OFFSET_MID);
        n_zone_mid++;
      end else if (t.range_cm > 0 && t.range_cm < ZONE_NEAR) begin
        range_offset = longint'(OFFSET_NEAR);
        n_zone_near++;
      end else begin
        range_offset = 0;
        n_zone_clear++;
      end
    end
    return res;
  endfunction

  function automatic void report_result(string what, drive_res_t want, drive_res_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("%s at %0t: want drive %0d lpwm %0d rpwm %0d fwd %0b en %0b", what, $realtime,
               want.drive, want.lpwm, want.rpwm, want.fwd, want.en);
      $display("  got drive %0d lpwm %0d rpwm %0d fwd %0b en %0b",
               got.drive, got.lpwm, got.rpwm, got.fwd, got.en);
    end
  endfunction

  // write all eight registers in index order, block idle
  task automatic apply_settings(input logic [15:0] vals [8]);
    for (int i = 0; i < 8; i++) begin
      reg_index_e idx;
      idx = reg_index_e'(i);
      cfg_we_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      case (idx)
        REG_TILT_REF:        ctl_cfg.tilt_ref = vals[i][14:0];
        REG_UPRIGHT_P_GAIN:  ctl_cfg.upright_p_gain = vals[i];
        REG_UPRIGHT_D_GAIN:  ctl_cfg.upright_d_gain = vals[i];
        REG_SPEED_P_GAIN:    ctl_cfg.speed_p_gain = vals[i];
        REG_SPEED_I_GAIN:    ctl_cfg.speed_i_gain = vals[i];
        REG_TARGET_SPEED:    ctl_cfg.target_speed = vals[i];
        REG_TARGET_POSITION: ctl_cfg.target_position = vals[i][14:0];
        REG_TILT_LIMIT:      ctl_cfg.tilt_limit = vals[i][13:0];
        default: ;
      endcase
    end
    cfg_we_i <= 1'b0;
    settings_loaded++;
  endtask

  // present one tick request, record its expected result on acceptance
  task automatic send_tick(tick_t t, logic typed, drive_res_t want);
    drive_res_t calc;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    tilt_angle_i <= t.tilt;
    gyro_rate_i <= t.gyro;
    left_count_i <= t.lcnt;
    right_count_i <= t.rcnt;
    range_distance_i <= t.range_cm;
    do @(posedge clk_i); while (!in_ready_o);
    calc = control_step(t);
    pending_drive_q.push_back(typed ? want : calc);
    ticks_sent++;
  endtask

  // stop sending until every expected result is back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_drive_q.size() != 0) @(posedge clk_i);
  endtask

  // result side: random stalls
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= out_stall_pct);
  end

  // result check against the oldest expectation
  always @(posedge clk_i) begin
    drive_res_t got;
    drive_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{drive_value_o, left_pwm_o, right_pwm_o, forward_o, motors_enabled_o};
      results_checked++;
      if (pending_drive_q.size() == 0) begin
        report_result("unexpected result", '0, got);
      end else begin
        want = pending_drive_q.pop_front();
        if (got !== want) report_result("drive mismatch", want, got);
      end
    end
  end

  // watchdog on cycles with no request moving on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // main sequence
  initial begin
    logic [15:0] vals [8];
    tick_t       t;
    int          burst_left;
    int          lim;
    int          org;
    int          r;
    logic        sgn;

    ctl_cfg = '0;
    ctl_cfg.tilt_limit = TILT_LIMIT_RESET;
    speed_filt = 0;
    speed_integ = 0;
    range_offset = 0;
    tick_cnt = 0;
    dir_hold = 1'b0;
    burst_left = 0;
    sgn = 1'b0;

    // reset-time gains are zero, so these results are known outright
    stim_rows.push_back('{'{15'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd0}, 1'b1, HELD_ON});
    stim_rows.push_back('{'{15'sd2880, 16'sd100, 16'sd3, 16'sd4, 16'd50}, 1'b1, HELD_ON});
    stim_rows.push_back('{'{-15'sd2880, -16'sd100, 16'sd0, 16'sd0, 16'd1}, 1'b1, HELD_ON});
    stim_rows.push_back('{'{15'sd2881, 16'sd0, 16'sd0, 16'sd0, 16'd0}, 1'b1, HELD_OFF});
    stim_rows.push_back('{'{-15'sd2881, 16'sd0, 16'sd0, 16'sd0, 16'd0}, 1'b1, HELD_OFF});
    stim_rows.push_back('{'{15'sh3fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'hffff},
                          1'b1, HELD_OFF});
    // most negative field values
    stim_rows.push_back('{'{15'sh4000, 16'sh8000, 16'sh8000, 16'sh8000, 16'h0000},
                          1'b1, HELD_OFF});
    stim_rows.push_back('{'{15'sd0, 16'sd0, 16'sh7fff, 16'sh7fff, 16'd5}, 1'b1, HELD_ON});
    stim_rows.push_back('{'{15'sd0, 16'sd0, 16'sh8000, 16'sh8000, 16'd9}, 1'b1, HELD_ON});
    // extreme gains: saturation both ways, zones at their edges
    stim_rows.push_back('{'{15'sd0, 16'sh7fff, 16'sd100, 16'sd100, 16'd10}, 1'b0, '0});
    stim_rows.push_back('{'{15'sd0, 16'sh8000, -16'sd100, -16'sd100, 16'd29}, 1'b0, '0});
    stim_rows.push_back('{'{15'sh3fff, 16'sd0, 16'sd0, 16'sd0, 16'd30}, 1'b0, '0});
    stim_rows.push_back('{'{15'sh4000, 16'sd0, 16'sd0, 16'sd0, 16'd1}, 1'b0, '0});
    stim_rows.push_back('{'{15'sd100, 16'sd500, 16'sh7fff, 16'sh7fff, 16'd9}, 1'b0, '0});
    stim_rows.push_back('{'{-15'sd100, -16'sd500, 16'sh8000, 16'sh8000, 16'hffff}, 1'b0, '0});
    stim_rows.push_back('{'{15'sd5000, 16'sh7fff, 16'sd0, 16'sd0, 16'd20}, 1'b0, '0});
    stim_rows.push_back('{'{-15'sd5000, 16'sh8000, 16'sd0, 16'sd0, 16'd0}, 1'b0, '0});
    stim_rows.push_back('{'{15'sd11520, 16'sd0, 16'sd1, -16'sd1, 16'd0}, 1'b0, '0});
    stim_rows.push_back('{'{15'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd0}, 1'b0, '0});

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed walk, no idling
    in_idle_pct = 0;
    out_stall_pct = 0;
    for (int i = 0; i < stim_rows.size(); i++) begin
      if (!stim_rows[i].typed && (i == 0 || stim_rows[i - 1].typed)) begin
        drain();
        vals = '{16'h0000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h8000,
                 16'd15000, 16'd11520};
        apply_settings(vals);
      end
      send_tick(stim_rows[i].t, stim_rows[i].typed, stim_rows[i].want);
    end
    drain();

    // random phases, each with its own register setting and idling mix
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin
          vals[0] = 16'(int'($urandom_range(400)) - 200);
          vals[1] = 16'(int'($urandom_range(4000)) - 2000);
          vals[2] = 16'(int'($urandom_range(400)) - 200);
          vals[3] = 16'(int'($urandom_range(2000)) - 1000);
          vals[4] = 16'(int'($urandom_range(200)) - 100);
          vals[5] = 16'(int'($urandom_range(100)) - 50);
          vals[6] = 16'(int'($urandom_range(2000)) - 1000);
          vals[7] = 16'd2880;
        end
        1: vals = '{16'h3fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                    16'h3fff, 16'h3fff};
        2: vals = '{16'h4000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                    16'h4000, 16'h0000};
        default: begin
          for (int k = 0; k < 8; k++) begin
            vals[k] = $urandom_range(1) ? 16'($urandom)
                                        : 16'(int'($urandom_range(2048)) - 1024);
          end
          if ($urandom_range(1)) vals[7] = 16'($urandom_range(4000, 200));
        end
      endcase
      apply_settings(vals);

      case (ph % 4)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 47; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 47; end
        default: begin in_idle_pct = 30; out_stall_pct = 30; end
      endcase

      org = int'($signed(ctl_cfg.tilt_ref));
      lim = int'(ctl_cfg.tilt_limit);
      if (lim > 6000) lim = 6000;

      for (int n = 0; n < PHASE_TICKS; n++) begin
        r = int'($urandom_range(99));
        // mostly plausible ticks near the reference angle
        t.tilt = 15'(org + int'($urandom_range(2 * lim)) - lim);
        t.gyro = $urandom_range(1) ? 16'(int'($urandom_range(6000)) - 3000) : 16'($urandom);
        t.lcnt = 16'(int'($urandom_range(400)) - 200);
        t.rcnt = 16'(int'($urandom_range(400)) - 200);
        t.range_cm = $urandom_range(1) ? 16'($urandom_range(40)) : 16'($urandom);
        if (burst_left > 0) begin
          // sustained full-speed encoder counts push the filter into saturation
          t.lcnt = sgn ? 16'(int'($urandom_range(300)) - 32768)
                       : 16'(32767 - int'($urandom_range(300)));
          t.rcnt = sgn ? 16'(int'($urandom_range(300)) - 32768)
                       : 16'(32767 - int'($urandom_range(300)));
          burst_left--;
        end else if (r >= 55 && r < 70) begin
          // right at the tilt limit, inside and just outside
          t.tilt = 15'(org + ($urandom_range(1) ? 1 : -1)
                   * (int'(ctl_cfg.tilt_limit) + int'($urandom_range(1))));
        end else if (r >= 70 && r < 80) begin
          burst_left = int'($urandom_range(30, 8));
          sgn = 1'($urandom_range(1));
        end else if (r >= 80) begin
          t = tick_t'({$urandom, $urandom, $urandom});
        end
        send_tick(t, 1'b0, '0);
      end
      drain();
    end

    // let any stray result show up
    repeat (30) @(posedge clk_i);

    $display("ran %0d control ticks over %0d register settings, %0d results compared",
             ticks_sent, settings_loaded, results_checked);
    $display("disabled %0d, drive sat %0d, filter sat %0d, integral clamp %0d, %s%0d/%0d/%0d",
             n_disabled, n_drive_sat, n_filt_sat, n_integ_clamp,
             "offsets near/mid/clear ", n_zone_near, n_zone_mid, n_zone_clear);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("status: fail");
    end
    $finish;
  end

endmodule
